### design/nmea_coordinate_to_degrees_top_macros.svh
// Assertion shorthands for the coordinate converter.
`ifndef NMEA_COORDINATE_TO_DEGREES_TOP_MACROS_SVH
`define NMEA_COORDINATE_TO_DEGREES_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define NCD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define NCD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### design/ncd_pkg.sv
package ncd_pkg;

  typedef enum logic [1:0] {
    PH_INT,
    PH_FRAC,
    PH_DONE
  } phase_t;

  localparam int OUT_W = 35;

  localparam logic [7:0] CH_POINT = 8'h2e;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SOUTH = 8'h53;
  localparam logic [7:0] CH_WEST  = 8'h57;

  function automatic longint unsigned pow10(input int n);
    longint unsigned p;
    p = 64'd1;
    for (int i = 0; i < n; i++) begin
      p = p * 64'd10;
    end
    return p;
  endfunction

endpackage

### design/nmea_coordinate_to_degrees_top.sv
// NMEA coordinate field (DDDMM.mmmm) to signed fixed-point decimal degrees.
// Input channel: in_valid / in_stall carry one character of the field per item,
// with field_last on the final character; hemisphere, is_longitude and
// checksum_ok are sampled with that final character.
// Output channel: out_valid / out_stall carry degrees_fixed (two's complement,
// OUT_FRAC_BITS fraction bits) and coord_valid; invalid fields give zero.
// One result per field, only when checksum_ok is high on the last character.
// Throughput: one character per cycle while in_stall is low. The minutes/60
// quotient and remainder are built up one digit per character from constant
// tables, so the last character needs only one add and compare.
// After the last character is accepted, the result passes through the snapshot
// register, then the output register, before it is offered.
// While out_stall holds a result, one more finished field waits in the
// snapshot register and characters keep flowing; in_stall rises only when
// both registers are full.
// Reset (rst, synchronous) clears the parser and empties both registers.
`include "nmea_coordinate_to_degrees_top_macros.svh"

module nmea_coordinate_to_degrees_top #(
  parameter int MAX_DEG_DIGITS = 3,
  parameter int FRAC_DIGITS    = 4,
  parameter int OUT_FRAC_BITS  = 24
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       ch,
  input  logic                             field_last,
  input  logic                             is_longitude,
  input  logic [7:0]                       hemisphere,
  input  logic                             checksum_ok,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [ncd_pkg::OUT_W-1:0] degrees_fixed,
  output logic                             coord_valid
);

  localparam longint unsigned SCALE = ncd_pkg::pow10(FRAC_DIGITS);
  localparam longint unsigned DENOM = 64'd60 * SCALE;
  localparam longint unsigned HALF  = DENOM / 64'd2;
  localparam longint unsigned ONE_F = 64'd1 << OUT_FRAC_BITS;
  localparam int DW   = $clog2(ncd_pkg::pow10(MAX_DEG_DIGITS));
  localparam int IMAX = MAX_DEG_DIGITS + 2;
  localparam int ICW  = $clog2(IMAX + 1);
  localparam int FCW  = $clog2(FRAC_DIGITS + 1);
  localparam int FIW  = (FRAC_DIGITS > 1) ? $clog2(FRAC_DIGITS) : 1;
  localparam int QW   = OUT_FRAC_BITS + 1;
  localparam int RW   = $clog2(DENOM);
  localparam int MW   = DW + QW + 1;
  localparam int XW   = (MW > ncd_pkg::OUT_W) ? MW : ncd_pkg::OUT_W;

  logic [QW-1:0] mm_q [10][10];
  logic [RW-1:0] mm_r [10][10];
  logic [QW-1:0] fd_q [FRAC_DIGITS][10];
  logic [RW-1:0] fd_r [FRAC_DIGITS][10];

  for (genvar h = 0; h < 10; h++) begin : g_mm_hi
    for (genvar l = 0; l < 10; l++) begin : g_mm_lo
      localparam longint unsigned NUM = 64'(10 * h + l) * SCALE * ONE_F + HALF;
      localparam longint unsigned QV  = NUM / DENOM;
      localparam longint unsigned RV  = NUM % DENOM;
      assign mm_q[h][l] = QW'(QV);
      assign mm_r[h][l] = RW'(RV);
    end
  end

  for (genvar k = 0; k < FRAC_DIGITS; k++) begin : g_fd_pos
    for (genvar d = 0; d < 10; d++) begin : g_fd_dig
      localparam longint unsigned NUM =
        64'(d) * ncd_pkg::pow10(FRAC_DIGITS - 1 - k) * ONE_F;
      localparam longint unsigned QV = NUM / DENOM;
      localparam longint unsigned RV = NUM % DENOM;
      assign fd_q[k][d] = QW'(QV);
      assign fd_r[k][d] = RW'(RV);
    end
  end

  ncd_pkg::phase_t phase, phase_next;
  logic [DW-1:0]   deg, deg_next;
  logic [3:0]      hi, hi_next, lo, lo_next;
  logic [ICW-1:0]  icnt, icnt_next;
  logic [FCW-1:0]  fcnt, fcnt_next;
  logic            perr, perr_next;
  logic [QW-1:0]   qacc, qacc_next;
  logic [RW-1:0]   racc, racc_next;

  logic            is_digit;
  logic [3:0]      dig;
  logic [FIW-1:0]  fidx;
  logic [RW:0]     rsum;

  logic            in_acc, out_load, s1_move;
  logic            fin_emit, fin_ok, fin_neg;

  logic            s1_valid;
  logic [DW-1:0]   s1_deg;
  logic [QW-1:0]   s1_q;
  logic            s1_ok, s1_neg;

  logic [XW-1:0]   mag, val;

  assign out_load = !out_valid || !out_stall;
  assign s1_move  = s1_valid && out_load;
  assign in_stall = s1_valid && !out_load;
  assign in_acc   = in_valid && !in_stall;

  assign is_digit = (ch >= ncd_pkg::CH_ZERO) && (ch <= ncd_pkg::CH_NINE);
  assign dig      = ch[3:0];
  assign fidx     = fcnt[FIW-1:0];
  assign rsum     = {1'b0, racc} + {1'b0, fd_r[fidx][dig]};

  always_comb begin
    phase_next = phase;
    deg_next   = deg;
    hi_next    = hi;
    lo_next    = lo;
    icnt_next  = icnt;
    fcnt_next  = fcnt;
    perr_next  = perr;
    qacc_next  = qacc;
    racc_next  = racc;
    unique case (phase)
      ncd_pkg::PH_INT: begin
        priority if (is_digit) begin
          if (icnt < ICW'(IMAX)) begin
            deg_next  = DW'(deg * DW'(10)) + DW'(hi);
            hi_next   = lo;
            lo_next   = dig;
            icnt_next = icnt + ICW'(1);
          end else begin
            perr_next = 1'b1;
          end
        end else if (ch == ncd_pkg::CH_POINT) begin
          phase_next = ncd_pkg::PH_FRAC;
          qacc_next  = mm_q[hi][lo];
          racc_next  = mm_r[hi][lo];
        end else begin
          perr_next = 1'b1;
        end
      end
      ncd_pkg::PH_FRAC: begin
        if (is_digit) begin
          if (rsum >= (RW + 1)'(DENOM)) begin
            racc_next = RW'(rsum - (RW + 1)'(DENOM));
            qacc_next = qacc + fd_q[fidx][dig] + QW'(1);
          end else begin
            racc_next = RW'(rsum);
            qacc_next = qacc + fd_q[fidx][dig];
          end
          fcnt_next = fcnt + FCW'(1);
          if (fcnt_next >= FCW'(FRAC_DIGITS)) begin
            phase_next = ncd_pkg::PH_DONE;
          end
        end else begin
          perr_next = 1'b1;
        end
      end
      ncd_pkg::PH_DONE: begin
        phase_next = phase;
      end
      default: begin
        phase_next = ncd_pkg::PH_INT;
      end
    endcase
  end

  always_comb begin
    fin_emit = in_acc && field_last && checksum_ok;
    fin_ok   = !perr_next && (phase_next == ncd_pkg::PH_DONE) && (icnt_next >= ICW'(2));
    fin_neg  = is_longitude ? (hemisphere == ncd_pkg::CH_WEST)
                            : (hemisphere == ncd_pkg::CH_SOUTH);
  end

  always_ff @(posedge clk) begin
    if (rst || (in_acc && field_last)) begin
      phase <= ncd_pkg::PH_INT;
      deg   <= '0;
      hi    <= '0;
      lo    <= '0;
      icnt  <= '0;
      fcnt  <= '0;
      perr  <= 1'b0;
      qacc  <= '0;
      racc  <= '0;
    end else if (in_acc) begin
      phase <= phase_next;
      deg   <= deg_next;
      hi    <= hi_next;
      lo    <= lo_next;
      icnt  <= icnt_next;
      fcnt  <= fcnt_next;
      perr  <= perr_next;
      qacc  <= qacc_next;
      racc  <= racc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (fin_emit) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_emit) begin
      s1_deg <= deg_next;
      s1_q   <= qacc_next;
      s1_ok  <= fin_ok;
      s1_neg <= fin_neg;
    end
  end

  assign mag = (XW'(s1_deg) << OUT_FRAC_BITS) + XW'(s1_q);
  assign val = s1_neg ? (~mag + XW'(1)) : mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      degrees_fixed <= s1_ok ? val[ncd_pkg::OUT_W-1:0] : '0;
      coord_valid   <= s1_ok;
    end
  end

  `NCD_ASSERT_NOW(a_invalid_zero, out_valid && !coord_valid, degrees_fixed == '0, "invalid item carries a nonzero value")
  `NCD_ASSERT_NOW(a_rem_bound, 1'b1, racc < RW'(DENOM), "minute remainder out of range")
  `NCD_ASSERT_NEXT(a_field_restart, in_acc && field_last, (phase == ncd_pkg::PH_INT) && (icnt == '0) && !perr, "parser not restarted after last character")
  `NCD_ASSERT_NOW(a_stall_full, in_stall, s1_valid && out_valid, "input stalled with a free register")

endmodule

### test/nmea_coordinate_to_degrees_checker.sv
`timescale 1ns / 1ps

module nmea_coordinate_to_degrees_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic [7:0]                       ch,
  input  logic                             field_last,
  input  logic                             is_longitude,
  input  logic [7:0]                       hemisphere,
  input  logic                             checksum_ok,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic signed [ncd_pkg::OUT_W-1:0] degrees_fixed,
  input  logic                             coord_valid,
  output int                               error_count,
  output int                               pending_count,
  output int                               result_count,
  output int                               valid_count
);

  localparam int INT_DIGITS_MAX = 5;
  localparam int FRAC_DIGITS    = 4;
  localparam int OUT_FRAC_BITS  = 24;
  localparam longint unsigned MINUTE_SCALE = 64'd10000;
  localparam longint unsigned MINUTE_DENOM = 64'd60 * MINUTE_SCALE;

  typedef struct packed {
    logic signed [ncd_pkg::OUT_W-1:0] degrees;
    logic                             ok;
  } coord_t;

  coord_t expected_coords[$];

  ncd_pkg::phase_t parse_ph;
  logic [16:0]     int_acc;
  logic [2:0]      int_cnt;
  logic [13:0]     frac_acc;
  logic [2:0]      frac_cnt;
  logic            bad_char;

  task automatic clear_parser();
    parse_ph = ncd_pkg::PH_INT;
    int_acc  = '0;
    int_cnt  = '0;
    frac_acc = '0;
    frac_cnt = '0;
    bad_char = 1'b0;
  endtask

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    error_count++;
  endtask

  always @(posedge clk) begin : watch
    coord_t          want;
    logic            digit;
    logic            neg;
    longint unsigned int_val;
    longint unsigned minute_units;
    longint unsigned frac_part;
    longint unsigned mag;
    if (rst) begin
      clear_parser();
    end else begin
      if (out_valid && !out_stall) begin
        result_count++;
        if (expected_coords.size() == 0) begin
          report_mismatch("result with no field pending");
        end else begin
          want = expected_coords.pop_front();
          if (want.ok) valid_count++;
          if (coord_valid !== want.ok)
            report_mismatch($sformatf("coord_valid got %b expected %b", coord_valid, want.ok));
          if (degrees_fixed !== want.degrees)
            report_mismatch($sformatf("degrees_fixed got %0d expected %0d",
                                      degrees_fixed, want.degrees));
        end
      end
      if (in_valid && !in_stall) begin
        digit = (ch >= ncd_pkg::CH_ZERO) && (ch <= ncd_pkg::CH_NINE);
        case (parse_ph)
          ncd_pkg::PH_INT: begin
            if (digit) begin
              if (int_cnt < INT_DIGITS_MAX) begin
                int_acc = 17'(int_acc * 10 + (ch - ncd_pkg::CH_ZERO));
                int_cnt = int_cnt + 1'b1;
              end else begin
                bad_char = 1'b1;
              end
            end else if (ch == ncd_pkg::CH_POINT) begin
              parse_ph = ncd_pkg::PH_FRAC;
            end else begin
              bad_char = 1'b1;
            end
          end
          ncd_pkg::PH_FRAC: begin
            if (digit) begin
              frac_acc = 14'(frac_acc * 10 + (ch - ncd_pkg::CH_ZERO));
              frac_cnt = frac_cnt + 1'b1;
              if (frac_cnt >= FRAC_DIGITS) parse_ph = ncd_pkg::PH_DONE;
            end else begin
              bad_char = 1'b1;
            end
          end
          default: ;
        endcase
        if (field_last) begin
          want.ok = !bad_char && parse_ph == ncd_pkg::PH_DONE && int_cnt >= 2 &&
                    frac_cnt == FRAC_DIGITS;
          want.degrees = '0;
          if (want.ok) begin
            int_val      = int_acc;
            minute_units = (int_val % 64'd100) * MINUTE_SCALE + frac_acc;
            frac_part    = ((minute_units << OUT_FRAC_BITS) + MINUTE_DENOM / 2) / MINUTE_DENOM;
            mag          = ((int_val / 64'd100) << OUT_FRAC_BITS) + frac_part;
            neg          = is_longitude ? (hemisphere == ncd_pkg::CH_WEST)
                                        : (hemisphere == ncd_pkg::CH_SOUTH);
            if (neg) mag = ~mag + 64'd1;
            want.degrees = mag[ncd_pkg::OUT_W-1:0];
          end
          if (checksum_ok) expected_coords.push_back(want);
          clear_parser();
        end
      end
    end
    pending_count = expected_coords.size();
  end

endmodule

### test/nmea_coordinate_to_degrees_top_test.sv
`timescale 1ns / 1ps

module nmea_coordinate_to_degrees_top_test;

  localparam logic [7:0] CH_NORTH = 8'h4e;
  localparam logic [7:0] CH_EAST  = 8'h45;
  localparam int CHARS_PER_PHASE  = 600;

  logic                             clk;
  logic                             rst;
  logic                             in_valid;
  logic                             in_stall;
  logic [7:0]                       ch;
  logic                             field_last;
  logic                             is_longitude;
  logic [7:0]                       hemisphere;
  logic                             checksum_ok;
  logic                             out_valid;
  logic                             out_stall;
  logic signed [ncd_pkg::OUT_W-1:0] degrees_fixed;
  logic                             coord_valid;

  int error_count;
  int pending_count;
  int result_count;
  int valid_count;

  int send_idle_pct;
  int recv_stall_pct;
  int chars_sent;
  int fields_sent;
  logic [7:0] field_chars[$];

  nmea_coordinate_to_degrees_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .ch           (ch),
    .field_last   (field_last),
    .is_longitude (is_longitude),
    .hemisphere   (hemisphere),
    .checksum_ok  (checksum_ok),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .degrees_fixed(degrees_fixed),
    .coord_valid  (coord_valid)
  );

  nmea_coordinate_to_degrees_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .ch           (ch),
    .field_last   (field_last),
    .is_longitude (is_longitude),
    .hemisphere   (hemisphere),
    .checksum_ok  (checksum_ok),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .degrees_fixed(degrees_fixed),
    .coord_valid  (coord_valid),
    .error_count  (error_count),
    .pending_count(pending_count),
    .result_count (result_count),
    .valid_count  (valid_count)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic send_char(input logic [7:0] c, input logic last, input logic lon,
                           input logic [7:0] hemi, input logic cs_ok);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    ch           <= c;
    field_last   <= last;
    is_longitude <= lon;
    hemisphere   <= hemi;
    checksum_ok  <= cs_ok;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    chars_sent++;
  endtask

  task automatic play_field(input logic lon, input logic [7:0] hemi, input logic cs_ok);
    int i;
    for (i = 0; i < field_chars.size(); i++)
      send_char(field_chars[i], i == field_chars.size() - 1, lon, hemi, cs_ok);
    fields_sent++;
    field_chars.delete();
  endtask

  task automatic load_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) field_chars.push_back(s[i]);
  endtask

  task automatic add_digits(input int n);
    int i;
    for (i = 0; i < n; i++) field_chars.push_back(ncd_pkg::CH_ZERO + 8'($urandom_range(9)));
  endtask

  task automatic random_field();
    int kind;
    int i;
    logic [7:0] hemi;
    kind = $urandom_range(99);
    if (kind < 80) begin
      add_digits(kind < 70 ? $urandom_range(2, 5) : $urandom_range(0, 7));
      if (kind < 70 || $urandom_range(1)) field_chars.push_back(ncd_pkg::CH_POINT);
      add_digits(kind < 70 ? 4 : $urandom_range(0, 6));
      if (kind < 70 && $urandom_range(99) < 20)
        for (i = $urandom_range(1, 3); i > 0; i--) field_chars.push_back(8'($urandom_range(255)));
    end else if (kind < 90) begin
      add_digits($urandom_range(2, 5));
      field_chars.push_back(ncd_pkg::CH_POINT);
      add_digits(4);
      field_chars[$urandom_range(field_chars.size() - 1)] = 8'($urandom_range(255));
    end else begin
      for (i = $urandom_range(1, 6); i > 0; i--) field_chars.push_back(8'($urandom_range(255)));
    end
    case ($urandom_range(19))
      0, 1, 2, 3: hemi = CH_NORTH;
      4, 5, 6, 7: hemi = ncd_pkg::CH_SOUTH;
      8, 9, 10, 11: hemi = CH_EAST;
      12, 13, 14, 15, 16: hemi = ncd_pkg::CH_WEST;
      default: hemi = 8'($urandom_range(255));
    endcase
    play_field(1'($urandom_range(1)), hemi, $urandom_range(9) != 0);
  endtask

  initial begin
    int phase;
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    ch           <= '0;
    field_last   <= 1'b0;
    is_longitude <= 1'b0;
    hemisphere   <= '0;
    checksum_ok  <= 1'b0;
    send_idle_pct  = 18;
    recv_stall_pct = 87;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    load_text("99999.9999");
    play_field(1'b1, ncd_pkg::CH_WEST, 1'b1);
    load_text("00.0000");
    play_field(1'b0, ncd_pkg::CH_SOUTH, 1'b1);
    load_text(".");
    play_field(1'b0, CH_NORTH, 1'b1);
    load_text("7");
    play_field(1'b1, CH_EAST, 1'b0);
    load_text("A");
    play_field(1'b0, CH_NORTH, 1'b1);
    load_text("12.3");
    play_field(1'b1, ncd_pkg::CH_WEST, 1'b1);

    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct  = (phase == 0) ? 18 : (phase == 1) ? 87 : 0;
      recv_stall_pct = (phase == 0) ? 87 : (phase == 1) ? 18 : 0;
      while (chars_sent < (phase + 1) * CHARS_PER_PHASE) random_field();
    end
    in_valid <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Fed %0d characters in %0d fields; checked %0d results, %0d valid coordinates.",
             chars_sent, fields_sent, result_count, valid_count);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
